// ===== rtl/arc_length_point_decimator_macros.svh =====
// Assertion macros used by the port checker file of the arc length point decimator.
`ifndef ARC_LENGTH_POINT_DECIMATOR_MACROS_SVH
`define ARC_LENGTH_POINT_DECIMATOR_MACROS_SVH

// Checked only outside reset.
`define ALPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ALPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/alpd_pkg.sv =====
// Types and constants of the arc length point decimator.
`default_nettype none
package alpd_pkg;

    localparam int unsigned SPACING_W = 20;
    localparam int unsigned INDEX_W   = 24;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd1500;
    localparam logic                 REG_SPACING   = 1'b0;

    localparam logic [2:0] SUMSQ_LAST = 3'd4;
    localparam logic [2:0] AXIS_X     = 3'd0;
    localparam logic [2:0] AXIS_Y     = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_LEN,
        ST_CMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic sqrt_start;
        logic emit_load;
        logic finish;
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/arc_length_point_decimator.sv =====
// Arc length point decimator: keeps path points roughly one spacing apart.
//
// Each incoming point holds o_in_stall high until the block is through with it. The
// first point of a path is kept straight away. For any other point the square root unit
// resolves ROOT_W bits, where ROOT_W = ceil(SUM_W/2), SUM_W = min(2*COORD_WIDTH+2, 64).
// One multiplier squares the three coordinate differences in turn, the square root
// unit then resolves one root bit per cycle, and the path length update, threshold
// compare and output load each take a state of their own. The output word sits in its
// own register, so a new point is accepted while a kept point waits to be taken; a
// further kept point that finds that word still waiting holds the block, with o_in_stall
// high, until the word is taken. Register spacing (byte address 0) sets the path distance
// between kept points in coordinate units; write it only while the block is idle.
`default_nettype none
module arc_length_point_decimator
    import alpd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH  = 24,
    parameter int unsigned LENGTH_WIDTH = 48
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,

    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  signed [COORD_WIDTH-1:0] i_px,
    input  wire  signed [COORD_WIDTH-1:0] i_py,
    input  wire  signed [COORD_WIDTH-1:0] i_pz,
    input  wire                           i_final_point,

    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_kept_x,
    output logic signed [COORD_WIDTH-1:0] o_kept_y,
    output logic signed [COORD_WIDTH-1:0] o_kept_z,
    output logic        [INDEX_W-1:0]     o_point_index,
    output logic                          o_path_end,

    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire         [APB_AW-1:0]      paddr,
    input  wire         [APB_DW-1:0]      pwdata,
    output logic        [APB_DW-1:0]      prdata,
    output logic                          pready
);

    localparam int unsigned CW     = COORD_WIDTH;
    localparam int unsigned LW     = LENGTH_WIDTH;
    localparam int unsigned PROD_W = 2 * CW;
    localparam int unsigned SUM_W  = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
    localparam int unsigned ROOT_W = (SUM_W + 1) / 2;

    t_state r_state, n_state;
    t_ctl   ctl;

    logic [SPACING_W-1:0] r_spacing;
    logic [CW-1:0]        r_last_x, r_last_y, r_last_z;
    logic [LW-1:0]        r_run, r_thr;
    logic                 r_first;
    logic [INDEX_W-1:0]   r_count;
    logic [2:0]           r_cnt;
    logic                 r_keep;
    logic                 r_out_valid;

    logic [CW-1:0]        r_px, r_py, r_pz;
    logic                 r_fin;
    logic [CW-1:0]        r_mag;
    logic [PROD_W-1:0]    r_prod;
    logic [SUM_W-1:0]     r_sum;
    logic [CW-1:0]        r_ox, r_oy, r_oz;
    logic [INDEX_W-1:0]   r_oidx;
    logic                 r_oend;

    logic [CW-1:0]        cur_c, last_c;
    logic [CW:0]          diff;
    logic [CW:0]          mag_full;
    logic [SUM_W:0]       sum_ext;
    logic [LW:0]          run_ext, thr_ext;
    logic                 sqrt_done;
    logic [ROOT_W-1:0]    root;
    logic                 cfg_wr;
    logic                 out_free;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SPACING);
    assign prdata = (paddr[2] == REG_SPACING) ? APB_DW'(r_spacing) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
        end else if (cfg_wr) begin
            r_spacing <= pwdata[SPACING_W-1:0];
        end
    end

    // Sequencer
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_first ? ST_EMIT : ST_SUMSQ;
                end
            end
            ST_SUMSQ: begin
                if (r_cnt == SUMSQ_LAST) begin
                    n_state = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO:   n_state = ST_ROOT_WAIT;
            ST_ROOT_WAIT: begin
                if (sqrt_done) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN:       n_state = ST_CMP;
            ST_CMP:       n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_keep || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl        = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                ctl.accept = i_in_valid;
            end
            ST_ROOT_GO: ctl.sqrt_start = 1'b1;
            ST_EMIT: begin
                ctl.finish    = !r_keep || out_free;
                ctl.emit_load = r_keep && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Squared distance: one shared multiplier, pipelined over the three axes
    always_comb begin
        case (r_cnt)
            AXIS_X: begin
                cur_c  = r_px;
                last_c = r_last_x;
            end
            AXIS_Y: begin
                cur_c  = r_py;
                last_c = r_last_y;
            end
            default: begin
                cur_c  = r_pz;
                last_c = r_last_z;
            end
        endcase
    end

    assign diff     = {cur_c[CW-1], cur_c} - {last_c[CW-1], last_c};
    assign mag_full = diff[CW] ? -diff : diff;
    assign sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (ctl.accept) begin
            r_cnt <= '0;
        end else if (r_state == ST_SUMSQ) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_px  <= i_px;
            r_py  <= i_py;
            r_pz  <= i_pz;
            r_fin <= i_final_point;
            r_sum <= '0;
        end else if (r_state == ST_SUMSQ) begin
            r_mag  <= mag_full[CW-1:0];
            r_prod <= r_mag * r_mag;
            if (r_cnt >= 3'd2) begin
                r_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            end
        end
    end

    alpd_isqrt #(
        .RAD_W (SUM_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.sqrt_start),
        .i_radicand (r_sum),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // Path length and threshold
    assign run_ext = {1'b0, r_run} + (LW + 1)'(root);
    assign thr_ext = {1'b0, r_thr} + (LW + 1)'(r_spacing);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_thr    <= '0;
            r_first  <= 1'b1;
            r_count  <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
            r_keep   <= 1'b0;
        end else begin
            if (ctl.accept && r_first) begin
                r_run  <= '0;
                r_thr  <= LW'(r_spacing);
                r_keep <= 1'b1;
            end
            if (r_state == ST_LEN) begin
                r_run <= run_ext[LW] ? '1 : run_ext[LW-1:0];
            end
            if (r_state == ST_CMP) begin
                r_keep <= (r_run > r_thr) || r_fin;
                if (r_run > r_thr) begin
                    r_thr <= thr_ext[LW] ? '1 : thr_ext[LW-1:0];
                end
            end
            if (ctl.finish) begin
                r_last_x <= r_px;
                r_last_y <= r_py;
                r_last_z <= r_pz;
                r_first  <= r_fin;
                r_count  <= r_fin ? '0 : r_count + 1'b1;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit_load) begin
            r_ox   <= r_px;
            r_oy   <= r_py;
            r_oz   <= r_pz;
            r_oidx <= r_count;
            r_oend <= r_fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kept_x      = r_ox;
    assign o_kept_y      = r_oy;
    assign o_kept_z      = r_oz;
    assign o_point_index = r_oidx;
    assign o_path_end    = r_oend;

endmodule
`default_nettype wire

// ===== rtl/alpd_isqrt.sv =====
// Bit-per-cycle integer square root, rounded down.
`default_nettype none
module alpd_isqrt
    import alpd_pkg::*;
#(
    parameter int unsigned RAD_W = 50
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [RAD_W-1:0]           i_radicand,
    output logic                       o_done,
    output logic [(RAD_W+1)/2-1:0]     o_root
);

    localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
    localparam int unsigned PAD_W  = 2 * ROOT_W;
    localparam int unsigned CNT_W  = $clog2(ROOT_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [PAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[PAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= PAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[PAD_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/alpd_checker.sv =====
// Port-level checks for the arc length point decimator, bound to its top level.
`default_nettype none
`include "arc_length_point_decimator_macros.svh"
module alpd_port_checker
    import alpd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 24
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input wire [COORD_WIDTH-1:0] o_kept_x,
    input wire [COORD_WIDTH-1:0] o_kept_y,
    input wire [COORD_WIDTH-1:0] o_kept_z,
    input wire [INDEX_W-1:0]     o_point_index,
    input wire                   o_path_end
);

    `ALPD_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid,
        "word valid after reset")

    `ALPD_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> o_in_stall, "point accepted on back-to-back cycles")

    `ALPD_ASSERT(a_out_valid_holds, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> o_out_valid, "stalled word dropped")

    `ALPD_ASSERT(a_out_word_holds, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> ($stable(o_kept_x) && $stable(o_kept_y)
            && $stable(o_kept_z) && $stable(o_point_index) && $stable(o_path_end)),
        "stalled word changed")

endmodule

bind arc_length_point_decimator alpd_port_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_alpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kept_x      (o_kept_x),
    .o_kept_y      (o_kept_y),
    .o_kept_z      (o_kept_z),
    .o_point_index (o_point_index),
    .o_path_end    (o_path_end)
);
`default_nettype wire

// ===== bench/alpd_checker.sv =====
// Checker for the arc length point decimator: predicts the kept points and compares each word.
module alpd_checker
    import alpd_pkg::*;
#(
    parameter int unsigned COORD_W  = 24,
    parameter int unsigned LENGTH_W = 48
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire signed [COORD_W-1:0]  i_px,
    input  wire signed [COORD_W-1:0]  i_py,
    input  wire signed [COORD_W-1:0]  i_pz,
    input  wire                       i_final_point,

    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire signed [COORD_W-1:0]  i_kept_x,
    input  wire signed [COORD_W-1:0]  i_kept_y,
    input  wire signed [COORD_W-1:0]  i_kept_z,
    input  wire        [INDEX_W-1:0]  i_point_index,
    input  wire                       i_path_end,

    input  wire                       i_psel,
    input  wire                       i_penable,
    input  wire                       i_pwrite,
    input  wire                       i_pready,
    input  wire        [APB_AW-1:0]   i_paddr,
    input  wire        [APB_DW-1:0]   i_pwdata,

    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    localparam logic [LENGTH_W-1:0] LEN_MAX      = '1;
    localparam logic [APB_AW-1:0]   SPACING_ADDR = {REG_SPACING, 2'b00};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [INDEX_W-1:0] index;
        logic               path_end;
    } t_kept_word;

    t_kept_word           kept_points_due[$];
    logic [SPACING_W-1:0] spacing_q;
    logic [COORD_W-1:0]   prev_x, prev_y, prev_z;
    logic [LENGTH_W-1:0]  path_len, next_mark;
    logic                 new_path;
    logic [INDEX_W-1:0]   path_pos;

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] r, c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] sq_delta(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0)
            d = -d;
        return 64'(d * d);
    endfunction

    function automatic logic [LENGTH_W-1:0] sat_len(input logic [LENGTH_W-1:0] a,
                                                   input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, 64'(a)} + {1'b0, b};
        return (s > {1'b0, 64'(LEN_MAX)}) ? LEN_MAX : s[LENGTH_W-1:0];
    endfunction

    task automatic advance_path(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z, input logic fin);
        t_kept_word  w;
        logic        keep;
        logic [63:0] sumsq;
        keep    = 1'b0;
        w.x     = x;
        w.y     = y;
        w.z     = z;
        w.index = path_pos;
        if (new_path) begin
            keep      = 1'b1;
            path_len  = '0;
            next_mark = LENGTH_W'(spacing_q);
            new_path  = 1'b0;
        end else begin
            sumsq    = sq_delta(x, prev_x) + sq_delta(y, prev_y) + sq_delta(z, prev_z);
            path_len = sat_len(path_len, floor_root(sumsq));
            if (path_len > next_mark) begin
                keep      = 1'b1;
                next_mark = sat_len(next_mark, 64'(spacing_q));
            end
        end
        prev_x   = x;
        prev_y   = y;
        prev_z   = z;
        path_pos = path_pos + 1'b1;
        if (fin) begin
            keep     = 1'b1;
            new_path = 1'b1;
            path_pos = '0;
        end
        w.path_end = fin;
        if (keep)
            kept_points_due = {kept_points_due, w};
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_kept_word head;
        if (!i_rst_n) begin
            kept_points_due.delete();
            spacing_q = SPACING_RESET;
            prev_x    = '0;
            prev_y    = '0;
            prev_z    = '0;
            path_len  = '0;
            next_mark = '0;
            new_path  = 1'b1;
            path_pos  = '0;
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SPACING_ADDR)
                spacing_q = i_pwdata[SPACING_W-1:0];
            if (i_out_valid && !i_out_stall) begin
                if (kept_points_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got (%0d,%0d,%0d) index %0d end %0d",
                             $time, i_kept_x, i_kept_y, i_kept_z, i_point_index, i_path_end);
                    o_errors++;
                end else begin
                    head = kept_points_due.pop_front();
                    check_field("kept_x", $signed(head.x), i_kept_x);
                    check_field("kept_y", $signed(head.y), i_kept_y);
                    check_field("kept_z", $signed(head.z), i_kept_z);
                    check_field("point_index", head.index, i_point_index);
                    check_field("path_end", head.path_end, i_path_end);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                advance_path(i_px, i_py, i_pz, i_final_point);
        end
        o_pending = kept_points_due.size();
    end

endmodule

// ===== bench/tb_arc_length_point_decimator.sv =====
// Testbench top for the arc length point decimator: clock, reset, stimulus and verdict.
module tb_arc_length_point_decimator;
    import alpd_pkg::*;

    localparam int unsigned         COORD_W       = 24;
    localparam int unsigned         LENGTH_W      = 48;
    localparam int                  CYCLE_LIMIT   = 1000000;
    localparam int                  SETTLE_CYCLES = 64;
    localparam logic [APB_AW-1:0]   SPACING_ADDR  = {REG_SPACING, 2'b00};
    localparam logic [SPACING_W-1:0] SPACING_MAX  = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [COORD_W-1:0]  px = '0, py = '0, pz = '0;
    logic                final_point = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COORD_W-1:0]  kept_x, kept_y, kept_z;
    logic [INDEX_W-1:0]  point_index;
    logic                path_end;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  errors, pending, checked;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_cycles = 0;
    int                  points_sent = 0;
    int                  cycles = 0;
    int                  path_left = 0;
    logic                mid_path = 1'b0;
    logic                in_took = 1'b0;
    logic                apb_took = 1'b0;
    logic [COORD_W-1:0]  cur_x = '0, cur_y = '0, cur_z = '0;
    logic [SPACING_W-1:0] cur_spacing = SPACING_RESET;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    arc_length_point_decimator #(
        .COORD_WIDTH  (COORD_W),
        .LENGTH_WIDTH (LENGTH_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_px          (px),
        .i_py          (py),
        .i_pz          (pz),
        .i_final_point (final_point),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kept_x      (kept_x),
        .o_kept_y      (kept_y),
        .o_kept_z      (kept_z),
        .o_point_index (point_index),
        .o_path_end    (path_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    alpd_checker #(
        .COORD_W  (COORD_W),
        .LENGTH_W (LENGTH_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_px          (px),
        .i_py          (py),
        .i_pz          (pz),
        .i_final_point (final_point),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_kept_x      (kept_x),
        .i_kept_y      (kept_y),
        .i_kept_z      (kept_z),
        .i_point_index (point_index),
        .i_path_end    (path_end),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always @(posedge clk) begin
        in_took  <= in_valid && !in_stall;
        apb_took <= psel && penable && pwrite && pready;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        px          <= x;
        py          <= y;
        pz          <= z;
        final_point <= fin;
        do @(negedge clk); while (!in_took);
        points_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_spacing(input logic [SPACING_W-1:0] v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPACING_ADDR;
        pwdata  <= APB_DW'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!apb_took);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_spacing = v;
    endtask

    // random walk with steps near the spacing, plus occasional jumps anywhere
    task automatic next_random_point();
        int   reach;
        logic fin;
        if (path_left == 0)
            path_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
        reach = (cur_spacing == 0) ? 1 : int'(cur_spacing);
        if (!mid_path || $urandom_range(0, 7) == 0) begin
            cur_x = COORD_W'($urandom());
            cur_y = COORD_W'($urandom());
            cur_z = COORD_W'($urandom());
        end else if ($urandom_range(0, 15) != 0) begin
            cur_x = cur_x + COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
            cur_y = cur_y + COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
            cur_z = cur_z + COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
        end
        fin = (path_left == 1);
        path_left--;
        mid_path = !fin;
        send_point(cur_x, cur_y, cur_z, fin);
    endtask

    task automatic run_phase(input logic [SPACING_W-1:0] spc, input int idle_pct,
                             input int stall, input int n);
        write_spacing(spc);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (n) next_random_point();
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-point path, then extreme corners
        send_point(24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        // straight line at reset spacing, one point lands exactly on the threshold
        for (int i = 0; i < 8; i++)
            send_point(COORD_W'(600 * i), 24'h000000, 24'h000000, i == 7);
        send_point(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b1);

        // zero spacing
        write_spacing('0);
        send_point(24'd5, 24'd5, 24'd5, 1'b0);
        send_point(24'd5, 24'd5, 24'd5, 1'b0);
        send_point(24'd6, 24'd5, 24'd5, 1'b0);
        send_point(24'd6, 24'd5, 24'd5, 1'b0);
        send_point(24'd6, 24'd6, 24'd5, 1'b1);

        // spacing changed mid-path
        send_point(24'd0, 24'd0, 24'd0, 1'b0);
        write_spacing(SPACING_MAX);
        send_point(24'd1, 24'd0, 24'd0, 1'b0);
        send_point(24'd2000, 24'd0, 24'd0, 1'b0);
        send_point(24'h7FFFFF, 24'd0, 24'd0, 1'b0);
        send_point(24'd0, 24'd0, 24'd0, 1'b1);

        run_phase(20'd1, 0, 0, 205);
        run_phase(SPACING_MAX, 64, 0, 205);
        run_phase(SPACING_RESET, 0, 64, 205);
        run_phase(SPACING_W'($urandom_range(1, 5000)), 22, 22, 205);

        // receiver holds off while points keep coming, then sender waits for all words
        write_spacing(20'd20000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 1500;
        repeat (100) next_random_point();
        wait_drained();
        send_idle_pct = 22;
        stall_pct     = 22;
        repeat (105) next_random_point();

        wait_drained();
        $display("Sent %0d points: corners, single-point paths, zero, minimum and maximum spacing,",
                 points_sent);
        $display("mid-path spacing changes, gaps, stalls and a long hold-off; %0d words checked.",
                 checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
